// ===== design/aic_pkg.sv =====
// Shared types and constants for the alarm indicator controller.
`timescale 1ns / 1ps

package aic_pkg;

	localparam int unsigned BLINK_W = 16;
	localparam int unsigned HOLD_W  = 20;
	localparam int unsigned CFG_W   = 20;
	localparam int unsigned IDX_W   = 2;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IMPACT = 2'd1,
		MODE_THEFT  = 2'd2
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_BLINK_ON  = 2'd0,
		REG_BLINK_OFF = 2'd1,
		REG_IMPACT_HOLD = 2'd2
	} reg_idx_t;

	localparam logic [BLINK_W-1:0] BLINK_ON_RST  = 16'd800;
	localparam logic [BLINK_W-1:0] BLINK_OFF_RST = 16'd200;
	localparam logic [HOLD_W-1:0]  HOLD_RST      = 20'd20000;

	typedef struct packed {
		logic [BLINK_W-1:0] blink_on;
		logic [BLINK_W-1:0] blink_off;
		logic [HOLD_W-1:0]  hold;
	} cfg_t;

	typedef struct packed {
		logic reset_req;
		logic theft_req;
		logic impact_req;
		logic tick;
	} item_t;

	typedef struct packed {
		logic  lamp;
		mode_t mode;
	} result_t;

endpackage

// ===== design/aic_core.sv =====
// Mode, blink and hold-timer state with its next-state logic.
`timescale 1ns / 1ps

module aic_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  aic_pkg::item_t  item,
	input  aic_pkg::cfg_t   cfg,
	output aic_pkg::result_t result_n
);
	import aic_pkg::*;

	mode_t              mode_q, mode_n;
	logic               phase_on_q, phase_on_n;
	logic               lamp_q, lamp_n;
	logic [BLINK_W-1:0] blink_q, blink_n;
	logic [HOLD_W-1:0]  hold_q, hold_n;
	logic               hold_run_q, hold_run_n;

	always_comb begin
		logic               expired;
		logic [HOLD_W-1:0]  hold_inc;
		logic [BLINK_W-1:0] blink_inc;
		logic [BLINK_W-1:0] limit;

		mode_n     = mode_q;
		phase_on_n = phase_on_q;
		lamp_n     = lamp_q;
		blink_n    = blink_q;
		hold_n     = hold_q;
		hold_run_n = hold_run_q;
		expired    = 1'b0;
		hold_inc   = hold_q + 1'b1;
		blink_inc  = blink_q + 1'b1;
		limit      = phase_on_q ? cfg.blink_on : cfg.blink_off;

		if (item.reset_req || item.theft_req || item.impact_req) begin
			if (item.reset_req) begin
				mode_n     = MODE_IDLE;
				lamp_n     = 1'b0;
				hold_run_n = 1'b0;
				hold_n     = '0;
			end else if (item.theft_req) begin
				mode_n     = MODE_THEFT;
				lamp_n     = 1'b1;
				hold_run_n = 1'b0;
				hold_n     = '0;
			end else if (mode_q != MODE_THEFT) begin
				mode_n     = MODE_IMPACT;
				phase_on_n = 1'b1;
				lamp_n     = 1'b1;
				hold_n     = '0;
				hold_run_n = 1'b1;
			end
			blink_n = '0;
		end else if (item.tick) begin
			if (hold_run_q) begin
				hold_n = hold_inc;
				// a zero limit, or a count wrapped to zero, expires at once
				if (hold_inc >= cfg.hold || hold_inc == '0) begin
					expired    = 1'b1;
					hold_run_n = 1'b0;
					hold_n     = '0;
					blink_n    = '0;
					if (mode_q == MODE_IMPACT) begin
						mode_n = MODE_IDLE;
						lamp_n = 1'b0;
					end
				end
			end
			if (!expired && mode_q == MODE_IMPACT) begin
				blink_n = blink_inc;
				if (blink_inc >= limit || blink_inc == '0) begin
					phase_on_n = !phase_on_q;
					lamp_n     = !phase_on_q;
					blink_n    = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			phase_on_q <= 1'b0;
			lamp_q     <= 1'b0;
			blink_q    <= '0;
			hold_q     <= '0;
			hold_run_q <= 1'b0;
		end else if (advance) begin
			mode_q     <= mode_n;
			phase_on_q <= phase_on_n;
			lamp_q     <= lamp_n;
			blink_q    <= blink_n;
			hold_q     <= hold_n;
			hold_run_q <= hold_run_n;
		end
	end

	assign result_n.lamp = lamp_n;
	assign result_n.mode = mode_n;

endmodule

// ===== design/alarm_indicator_controller.sv =====
// Alarm indicator controller top level: channel registers, configuration and checks.
`timescale 1ns / 1ps

// Takes one transaction per clock while in_stall is low and returns one result per
// transaction: the item is captured in an input register, the mode, blink and
// hold-timer update runs in one pass of logic, and the lamp level and mode land
// in an output register. The output register lets a new item enter while a
// result still waits; in_stall rises only when both registers are full and
// out_stall is high. Configuration writes take effect on the next item.
module alarm_indicator_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        reset_request,
	input  logic                        theft_request,
	input  logic                        impact_request,
	input  logic                        tick,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        lamp_level,
	output logic [1:0]                  alarm_mode,
	input  logic                        cfg_write_en,
	input  logic [aic_pkg::IDX_W-1:0]   cfg_index,
	input  logic [aic_pkg::CFG_W-1:0]   cfg_data
);
	import aic_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	result_t res_n;
	logic    valid_s2;
	logic    s2_ready;
	logic    advance;

	assign s2_ready = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_ready;
	assign in_stall = valid_s1 && !s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_on  <= BLINK_ON_RST;
			cfg_q.blink_off <= BLINK_OFF_RST;
			cfg_q.hold      <= HOLD_RST;
		end else if (cfg_write_en) begin
			case (reg_idx_t'(cfg_index))
				REG_BLINK_ON:    cfg_q.blink_on  <= cfg_data[BLINK_W-1:0];
				REG_BLINK_OFF:   cfg_q.blink_off <= cfg_data[BLINK_W-1:0];
				REG_IMPACT_HOLD: cfg_q.hold      <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (s2_ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.reset_req  <= reset_request;
			item_s1.theft_req  <= theft_request;
			item_s1.impact_req <= impact_request;
			item_s1.tick       <= tick;
		end
		if (advance)
			res_s2 <= res_n;
	end

	aic_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.cfg      (cfg_q),
		.result_n (res_n)
	);

	assign out_valid  = valid_s2;
	assign lamp_level = res_s2.lamp;
	assign alarm_mode = res_s2.mode;

	a_theft_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alarm_mode == MODE_THEFT |-> lamp_level)
		else $error("theft mode with lamp dark");

	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alarm_mode == MODE_IDLE |-> !lamp_level)
		else $error("idle mode with lamp lit");

	a_reset_req: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.reset_req |=>
			out_valid && alarm_mode == MODE_IDLE && !lamp_level)
		else $error("reset request did not clear the alarm");

endmodule
